### design/ble_pkg.sv
package ble_pkg;

    localparam int AVG_LOG2   = 4;
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = SAMPLE_W + AVG_LOG2;
    localparam int GAIN_W     = 24;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int MV_W       = 16;
    localparam int PCT_W      = 7;
    localparam int IDX_W      = 4;
    localparam int SEG_W      = 10;
    localparam int REM_W      = 13;
    localparam int QUO_W      = 4;
    localparam int TABLE_LEN  = 11;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd555185;
    localparam logic [MV_W-1:0]   MV_MAX     = 16'hFFFF;
    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_EMPTY  = 7'd0;
    localparam logic [IDX_W-1:0]  IDX_LAST   = 4'(TABLE_LEN - 1);

    // Register word addresses
    localparam logic [ADDR_W-3:0] REG_GAIN = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } t_state;

    // Battery voltage breakpoints, 10 percent apart
    function automatic logic [MV_W-1:0] level_mv(input logic [IDX_W-1:0] idx);
        logic [MV_W-1:0] v;
        unique case (idx)
            4'd0:    v = 16'd3000;
            4'd1:    v = 16'd3650;
            4'd2:    v = 16'd3700;
            4'd3:    v = 16'd3740;
            4'd4:    v = 16'd3760;
            4'd5:    v = 16'd3795;
            4'd6:    v = 16'd3840;
            4'd7:    v = 16'd3910;
            4'd8:    v = 16'd3980;
            4'd9:    v = 16'd4070;
            default: v = 16'd4150;
        endcase
        return v;
    endfunction

    // Width of the segment that ends at breakpoint idx
    function automatic logic [SEG_W-1:0] seg_mv(input logic [IDX_W-1:0] idx);
        logic [SEG_W-1:0] v;
        unique case (idx)
            4'd1:    v = 10'd650;
            4'd2:    v = 10'd50;
            4'd3:    v = 10'd40;
            4'd4:    v = 10'd20;
            4'd5:    v = 10'd35;
            4'd6:    v = 10'd45;
            4'd7:    v = 10'd70;
            4'd8:    v = 10'd70;
            4'd9:    v = 10'd90;
            default: v = 10'd80;
        endcase
        return v;
    endfunction

endpackage

### design/battery_level_estimator_core.sv
// Channel    | Handshake                 | Payload
// -----------+---------------------------+-------------------------------
// sample in  | i_valid / o_ready         | i_sample[11:0]
// result out | o_valid / i_ready         | o_voltage_mv[15:0], o_percent[6:0]
// config     | psel/penable/pwrite/pready| paddr[2:0], pwdata, prdata
//
// A sample that does not close a group of 16 is accumulated; o_ready stays high.
// The sample that closes a group starts the sequencer: multiply, saturate,
// table scan (one breakpoint compare per cycle), divide (one quotient
// bit per cycle, only for a voltage inside the table), hand-off; how long
// it runs is set by where the voltage falls in the table.
// o_ready is low while the sequencer runs. A finished result sits in the output
// register until taken; samples keep accumulating meanwhile, and a new group end
// waits in the hand-off state while the previous result is still held.
// Reset is synchronous, active low; it clears the sum, count, sequencer and o_valid
// and restores the default gain.
module battery_level_estimator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ble_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ble_pkg::MV_W-1:0]           o_voltage_mv,
    output logic [ble_pkg::PCT_W-1:0]          o_percent,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ble_pkg::ADDR_W-1:0]         paddr,
    input  logic [ble_pkg::DATA_W-1:0]         pwdata,
    output logic [ble_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    ble_pkg::t_state r_state, n_state;

    logic [ble_pkg::GAIN_W-1:0]   r_gain;
    logic [ble_pkg::SUM_W-1:0]    r_sum;
    logic [ble_pkg::AVG_LOG2-1:0] r_count;
    logic [ble_pkg::SAMPLE_W-1:0] r_mean;
    logic [ble_pkg::PROD_W-1:0]   r_prod;
    logic [ble_pkg::MV_W-1:0]     r_mv;
    logic [ble_pkg::IDX_W-1:0]    r_idx;
    logic [ble_pkg::REM_W-1:0]    r_rem;
    logic [ble_pkg::SEG_W-1:0]    r_den;
    logic [1:0]                   r_bit;
    logic [ble_pkg::QUO_W-1:0]    r_quo;
    logic [ble_pkg::PCT_W-1:0]    r_base;
    logic [ble_pkg::PCT_W-1:0]    r_pct;
    logic                         r_pct_done;
    logic                         r_out_valid;
    logic [ble_pkg::MV_W-1:0]     r_out_mv;
    logic [ble_pkg::PCT_W-1:0]    r_out_pct;

    logic                         in_fire;
    logic                         out_fire;
    logic                         group_end;
    logic [ble_pkg::SUM_W-1:0]    sum_next;
    logic                         cfg_write;
    logic                         load_out;

    // Shared subtractor: breakpoint compare during the scan, trial subtract
    // during the divide.
    logic [ble_pkg::MV_W-1:0]     sub_a;
    logic [ble_pkg::MV_W-1:0]     sub_b;
    logic [ble_pkg::MV_W:0]       sub_diff;
    logic                         sub_borrow;

    logic [ble_pkg::MV_W-1:0]     to_top;
    logic [ble_pkg::SEG_W-1:0]    to_top_n;
    logic [ble_pkg::REM_W-1:0]    num_init;
    logic [ble_pkg::REM_W-1:0]    den_shift;

    assign in_fire   = i_valid && o_ready;
    assign out_fire  = r_out_valid && i_ready;
    assign group_end = (r_count == {ble_pkg::AVG_LOG2{1'b1}});
    assign sum_next  = r_sum + ble_pkg::SUM_W'(i_sample);
    assign cfg_write = psel && penable && pwrite && pready;
    assign load_out  = (r_state == ble_pkg::ST_DONE) && (!r_out_valid || i_ready);

    assign den_shift = ble_pkg::REM_W'(r_den) << r_bit;

    always_comb begin
        unique case (r_state)
            ble_pkg::ST_DIV: begin
                sub_a = ble_pkg::MV_W'(r_rem);
                sub_b = ble_pkg::MV_W'(den_shift);
            end
            default: begin
                sub_a = r_mv;
                sub_b = ble_pkg::level_mv(r_idx);
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[ble_pkg::MV_W];

    // Distance to the segment's upper breakpoint, times ten
    assign to_top   = ble_pkg::level_mv(r_idx) - r_mv;
    assign to_top_n = to_top[ble_pkg::SEG_W-1:0];
    assign num_init = (ble_pkg::REM_W'(to_top_n) << 3) + (ble_pkg::REM_W'(to_top_n) << 1);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ble_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            ble_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && group_end) begin
                    n_state = ble_pkg::ST_MUL;
                end
            end
            ble_pkg::ST_MUL:  n_state = ble_pkg::ST_SAT;
            ble_pkg::ST_SAT:  n_state = ble_pkg::ST_SCAN;
            ble_pkg::ST_SCAN: begin
                // Stop at the first breakpoint above the voltage, or past the top
                if (sub_borrow) begin
                    n_state = (r_idx == '0) ? ble_pkg::ST_DONE : ble_pkg::ST_DIV;
                end else if (r_idx == ble_pkg::IDX_LAST) begin
                    n_state = ble_pkg::ST_DONE;
                end
            end
            ble_pkg::ST_DIV: begin
                if (r_bit == 2'd0) begin
                    n_state = ble_pkg::ST_DONE;
                end
            end
            ble_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ble_pkg::ST_IDLE;
                end
            end
            default: n_state = ble_pkg::ST_IDLE;
        endcase
    end

    // Accumulator and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_gain  <= ble_pkg::GAIN_RESET;
        end else begin
            if (in_fire) begin
                r_count <= r_count + 1'b1;
                // Clear the sum when the group closes
                r_sum   <= group_end ? '0 : sum_next;
            end
            if (cfg_write && (paddr[ble_pkg::ADDR_W-1:2] == ble_pkg::REG_GAIN)) begin
                r_gain <= pwdata[ble_pkg::GAIN_W-1:0];
            end
        end
    end

    // Datapath: no reset needed, the sequencer qualifies every register
    always_ff @(posedge i_clk) begin
        if (in_fire && group_end) begin
            r_mean <= sum_next[ble_pkg::SUM_W-1:ble_pkg::AVG_LOG2];
        end
        unique case (r_state)
            ble_pkg::ST_MUL: begin
                r_prod <= ble_pkg::PROD_W'(r_mean) * ble_pkg::PROD_W'(r_gain);
            end
            ble_pkg::ST_SAT: begin
                // Saturate anything above 16 integer bits
                r_mv       <= (|r_prod[ble_pkg::PROD_W-1:ble_pkg::MV_W+16]) ?
                              ble_pkg::MV_MAX : r_prod[ble_pkg::MV_W+15:16];
                r_idx      <= '0;
                r_pct_done <= 1'b0;
            end
            ble_pkg::ST_SCAN: begin
                if (sub_borrow) begin
                    r_pct  <= ble_pkg::PCT_EMPTY;
                    r_rem  <= num_init;
                    r_den  <= ble_pkg::seg_mv(r_idx);
                    r_base <= (ble_pkg::PCT_W'(r_idx) << 3) + (ble_pkg::PCT_W'(r_idx) << 1);
                    r_bit  <= 2'd3;
                    r_quo  <= '0;
                end else if (r_idx == ble_pkg::IDX_LAST) begin
                    r_pct <= ble_pkg::PCT_FULL;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            ble_pkg::ST_DIV: begin
                // Restoring divide, one quotient bit per cycle
                if (!sub_borrow) begin
                    r_rem          <= sub_diff[ble_pkg::REM_W-1:0];
                    r_quo[r_bit]   <= 1'b1;
                end
                r_bit <= r_bit - 1'b1;
                if (r_bit == 2'd0) begin
                    r_pct_done <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mv  <= r_mv;
            r_out_pct <= r_pct_done ? (r_base - ble_pkg::PCT_W'(r_quo)) : r_pct;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_voltage_mv = r_out_mv;
    assign o_percent    = r_out_pct;

    assign pready = 1'b1;
    assign prdata = (paddr[ble_pkg::ADDR_W-1:2] == ble_pkg::REG_GAIN) ?
                    ble_pkg::DATA_W'(r_gain) : '0;

endmodule

### design/ble_checker.sv
module ble_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [ble_pkg::MV_W-1:0]      o_voltage_mv,
    input logic [ble_pkg::PCT_W-1:0]     o_percent
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_voltage_mv) && $stable(o_percent))
        else $error("result changed while stalled");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_percent <= ble_pkg::PCT_FULL)
        else $error("percent above full scale");

    a_pct_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_voltage_mv < 16'd3000) ? (o_percent == ble_pkg::PCT_EMPTY) :
                     (o_voltage_mv >= 16'd4150) ? (o_percent == ble_pkg::PCT_FULL) : 1'b1))
        else $error("percent wrong outside the table");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

endmodule

bind battery_level_estimator_core ble_checker u_ble_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_voltage_mv (o_voltage_mv),
    .o_percent    (o_percent)
);
